// ===== hw/rtl/dep_pkg.sv =====
// Shared types, codes and helpers of the delta escape pixel decoder.
`default_nettype none
package dep_pkg;

  localparam int AuxDepthDefault = 4096;
  localparam int CfgIdxW         = 3;
  localparam int AuxCountW       = 13;
  localparam int UnusedW         = 12;
  localparam int QShift          = 16;

  localparam logic [7:0] EscapeCode = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_OFFSET = 3'd1,
    CFG_ZERO   = 3'd2,
    CFG_FORMAT = 3'd3,
    CFG_COUNT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_DIFF   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  localparam logic [1:0] FMT_BYTE  = 2'd0;
  localparam logic [1:0] FMT_SHORT = 2'd1;
  localparam logic [1:0] FMT_LONG  = 2'd2;

  // running value action in the second front stage
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_RELOAD = 2'd1,
    OP_ADD    = 2'd2
  } run_op_t;

  typedef struct packed {
    logic signed [31:0] scale;
    logic signed [31:0] offset;
    logic signed [31:0] zero_lvl;
    logic        [1:0]  fmt;
    logic               scale_on;
    logic signed [48:0] bias;      // offset - zero_lvl * 2^16
  } cfg_t;

  // per-beat control that rides along the pixel pipeline
  typedef struct packed {
    logic               vld;
    logic               err;
    logic               summary;
    logic [UnusedW-1:0] unused;
  } pipe_ctl_t;

  function automatic int cnt_width(input int depth);
    int w;
    w = $clog2(depth + 1);
    return (w > AuxCountW) ? w : AuxCountW;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/delta_escape_pixel_decoder_unit.sv =====
// Top level of the delta escape pixel decoder.
`default_nettype none
// Delta escape pixel decoder. Input beats (s_tuser = kind) either load a 16-bit
// auxiliary word into an on-chip store, start an image (running value takes word 0),
// add a signed difference byte to the running value, or finish an image. The
// difference byte 0x80 is an escape: the running value takes the next auxiliary
// word; if the pointer has run past the configured word count the beat reports
// escape_error and repeats the held value. Each difference beat yields one
// pixel: running * scale + offset (Q16.16) minus zero_level, truncated toward zero,
// saturated to byte, short or 32-bit range; a scale of 0 or 1.0 bypasses the
// multiply and the offset. A finish beat yields one summary beat carrying the
// number of words never consumed. Load and start beats yield nothing.
// Throughput is one beat per clock unless stalled: the store has one write and one
// read port and every beat uses at most one of them, so no beat ever waits on
// another for the store. An accepted beat reaches the master-side register through
// the store read, then running value update, multiply, bias add, truncation and
// saturation, each step ending in its own register, in that order. The whole pipeline
// advances together; it stalls only while a result sits on the master side
// and m_tready is low. Configuration goes through cfg_* (always ready) and must
// only be written while the decoder is drained. The store has no reset; reading a
// word that was never loaded returns whatever the RAM holds.
module delta_escape_pixel_decoder_unit #(
  parameter int AUX_DEPTH = dep_pkg::AuxDepthDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // slave side
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [39:0]                 s_tdata,  // aux_index[11:0], aux_value[27:12],
                                                     // diff_byte[35:28], zero pad
  input  wire logic [1:0]                  s_tuser,  // kind[1:0]
  // master side
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [47:0]                 m_tdata,  // pixel[31:0], escape_error[32],
                                                     // unused_aux[44:33], zero pad
  output      logic [0:0]                  m_tuser,  // is_summary[0]
  // configuration write channel
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [dep_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data
);
  import dep_pkg::*;

  localparam int CW = cnt_width(AUX_DEPTH);

  cfg_t               cfg;
  logic [CW-1:0]      eff_count;
  logic               en;
  logic               acc;
  logic signed [31:0] running_value;
  pipe_ctl_t          c_ctl;
  pipe_ctl_t          out_ctl;
  logic [31:0]        out_pixel;

  // global pipeline advance: output register empty or being drained
  assign en       = !out_ctl.vld || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && en;

  dep_cfg_regs #(.AUX_DEPTH(AUX_DEPTH)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .eff_count(eff_count)
  );

  dep_decode_front #(.AUX_DEPTH(AUX_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .acc          (acc),
    .kind         (kind_t'(s_tuser)),
    .aux_index    (s_tdata[11:0]),
    .aux_value    (s_tdata[27:12]),
    .diff_byte    (s_tdata[35:28]),
    .eff_count    (eff_count),
    .running_value(running_value),
    .c_ctl        (c_ctl)
  );

  dep_scale_pipe u_scale (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .running_value(running_value),
    .c_ctl        (c_ctl),
    .out_ctl      (out_ctl),
    .out_pixel    (out_pixel)
  );

  assign m_tvalid = out_ctl.vld;
  assign m_tdata  = {3'd0, out_ctl.unused, out_ctl.err, out_pixel};
  assign m_tuser  = out_ctl.summary;

endmodule
`default_nettype wire

// ===== hw/rtl/dep_cfg_regs.sv =====
// Configuration register file with derived scaling terms and clamped word count.
`default_nettype none
module dep_cfg_regs #(
  parameter int AUX_DEPTH = dep_pkg::AuxDepthDefault,
  localparam int CW = dep_pkg::cnt_width(AUX_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [dep_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data,
  output      dep_pkg::cfg_t               cfg,
  output      logic [CW-1:0]               eff_count
);
  import dep_pkg::*;

  localparam int EffReset = (AUX_DEPTH < 4096) ? AUX_DEPTH : 4096;

  logic signed [31:0] scale;
  logic signed [31:0] offset;
  logic signed [31:0] zero_lvl;
  logic [1:0]         fmt;
  logic signed [48:0] bias;
  logic [CW-1:0]      eff_next;
  logic [31:0]        cnt32;

  assign cfg_ready = 1'b1;

  // clamp count into 1..AUX_DEPTH at write time
  always_comb begin
    cnt32 = {{(32-AuxCountW){1'b0}}, cfg_data[AuxCountW-1:0]};
    if (cnt32 == 32'd0) begin
      eff_next = CW'(1);
    end else if (cnt32 > 32'(AUX_DEPTH)) begin
      eff_next = CW'(AUX_DEPTH);
    end else begin
      eff_next = CW'(cnt32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= 32'sd65536;
      offset    <= '0;
      zero_lvl  <= '0;
      fmt       <= FMT_SHORT;
      eff_count <= CW'(EffReset);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCALE:  scale     <= cfg_data;
        CFG_OFFSET: offset    <= cfg_data;
        CFG_ZERO:   zero_lvl  <= cfg_data;
        CFG_FORMAT: fmt       <= cfg_data[1:0];
        CFG_COUNT:  eff_count <= eff_next;
        default:    ;
      endcase
    end
  end

  // bias is registered; it is first used in the bias add of the back end
  always_ff @(posedge clk) begin
    bias <= {{17{offset[31]}}, offset} - {zero_lvl[31], zero_lvl, {QShift{1'b0}}};
  end

  always_comb begin
    cfg.scale    = scale;
    cfg.offset   = offset;
    cfg.zero_lvl = zero_lvl;
    cfg.fmt      = fmt;
    cfg.scale_on = (scale != 32'sd0) && (scale != 32'sd65536);
    cfg.bias     = bias;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dep_aux_ram.sv =====
// Auxiliary word store: one write port, one registered read port.
`default_nettype none
module dep_aux_ram #(
  parameter int DEPTH = dep_pkg::AuxDepthDefault,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [15:0]   rdata
);
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dep_decode_front.sv =====
// Front end: word pointer, store access and running value update.
`default_nettype none
module dep_decode_front #(
  parameter int AUX_DEPTH = dep_pkg::AuxDepthDefault,
  localparam int CW = dep_pkg::cnt_width(AUX_DEPTH),
  localparam int AW = $clog2(AUX_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        acc,
  input  wire dep_pkg::kind_t              kind,
  input  wire logic [11:0]                 aux_index,
  input  wire logic [15:0]                 aux_value,
  input  wire logic [7:0]                  diff_byte,
  input  wire logic [CW-1:0]               eff_count,
  output      logic signed [31:0]          running_value,
  output      dep_pkg::pipe_ctl_t          c_ctl
);
  import dep_pkg::*;

  logic [AW-1:0]    aux_pointer;
  logic [AW-1:0]    aux_pointer_next;
  logic [AW-1:0]    rd_addr;
  logic [15:0]      rd_data;
  logic             we;
  logic [31:0]      idx32;
  logic [CW-1:0]    ptr_inc;
  logic             no_word;
  logic             is_esc;
  logic signed [CW:0] unused_raw;
  logic [UnusedW-1:0] unused_sat;
  run_op_t          op_a;
  pipe_ctl_t        ctl_a;

  // second stage
  run_op_t          b_op;
  logic [7:0]       b_diff;
  pipe_ctl_t        b_ctl;
  logic signed [31:0] running_next;

  assign idx32   = {20'd0, aux_index};
  assign we      = acc && (kind == KIND_LOAD) && (idx32 < 32'(AUX_DEPTH));
  assign is_esc  = (diff_byte == EscapeCode);
  assign ptr_inc = CW'(aux_pointer) + CW'(1);
  assign no_word = (ptr_inc >= eff_count);

  always_comb begin
    unused_raw = $signed({1'b0, eff_count}) - (CW+1)'(1) - $signed({1'b0, CW'(aux_pointer)});
    if (unused_raw < 0) begin
      unused_sat = '0;
    end else if (unused_raw > (CW+1)'(4095)) begin
      unused_sat = '1;
    end else begin
      unused_sat = unused_raw[UnusedW-1:0];
    end
  end

  always_comb begin
    op_a             = OP_NONE;
    aux_pointer_next = aux_pointer;
    rd_addr          = aux_pointer + AW'(1);
    ctl_a            = '0;
    unique case (kind)
      KIND_LOAD: begin
        op_a = OP_NONE;
      end
      KIND_START: begin
        op_a             = OP_RELOAD;
        aux_pointer_next = '0;
        rd_addr          = '0;
      end
      KIND_DIFF: begin
        ctl_a.vld = 1'b1;
        if (is_esc) begin
          if (no_word) begin
            ctl_a.err = 1'b1;
          end else begin
            op_a             = OP_RELOAD;
            aux_pointer_next = aux_pointer + AW'(1);
          end
        end else begin
          op_a = OP_ADD;
        end
      end
      KIND_FINISH: begin
        ctl_a.vld     = 1'b1;
        ctl_a.summary = 1'b1;
        ctl_a.unused  = unused_sat;
      end
      default: ;
    endcase
  end

  dep_aux_ram #(.DEPTH(AUX_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(idx32[AW-1:0]),
    .wdata(aux_value),
    .re   (en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      aux_pointer <= '0;
    end else if (acc) begin
      aux_pointer <= aux_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_op    <= OP_NONE;
      b_ctl   <= '0;
      c_ctl   <= '0;
    end else if (en) begin
      b_op    <= acc ? op_a : OP_NONE;
      b_ctl   <= acc ? ctl_a : '0;
      c_ctl   <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_diff <= diff_byte;
    end
  end

  always_comb begin
    running_next = running_value;
    case (b_op)
      OP_RELOAD: running_next = {{16{rd_data[15]}}, rd_data};
      OP_ADD:    running_next = running_value + {{24{b_diff[7]}}, b_diff};
      default:   running_next = running_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
    end else if (en) begin
      running_value <= running_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dep_scale_pipe.sv =====
// Pixel back end: Q16.16 scale, offset, level shift, truncate, saturate.
`default_nettype none
module dep_scale_pipe (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire dep_pkg::cfg_t      cfg,
  input  wire logic signed [31:0] running_value,
  input  wire dep_pkg::pipe_ctl_t c_ctl,
  output      dep_pkg::pipe_ctl_t out_ctl,
  output      logic [31:0]        out_pixel
);
  import dep_pkg::*;

  pipe_ctl_t          d_ctl;
  pipe_ctl_t          e_ctl;
  pipe_ctl_t          f_ctl;
  logic signed [63:0] d_prod;
  logic signed [32:0] d_diff;
  logic signed [64:0] e_q;
  logic signed [32:0] e_diff;
  logic signed [48:0] quo;
  logic signed [48:0] f_v;
  logic signed [48:0] sat_lo;
  logic signed [48:0] sat_hi;
  logic signed [48:0] sat_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl   <= '0;
      e_ctl   <= '0;
      f_ctl   <= '0;
      out_ctl <= '0;
    end else if (en) begin
      d_ctl   <= c_ctl;
      e_ctl   <= d_ctl;
      f_ctl   <= e_ctl;
      out_ctl <= f_ctl;
    end
  end

  // truncate toward zero: floor shift, then bump negatives with a remainder
  always_comb begin
    quo = e_q[64:QShift];
    if (e_q[64] && (e_q[QShift-1:0] != '0)) begin
      quo = quo + 49'sd1;
    end
  end

  always_comb begin
    case (cfg.fmt)
      FMT_BYTE: begin
        sat_lo = 49'sd0;
        sat_hi = 49'sd255;
      end
      FMT_SHORT: begin
        sat_lo = -49'sd32768;
        sat_hi = 49'sd32767;
      end
      default: begin
        sat_lo = -49'sd2147483648;
        sat_hi = 49'sd2147483647;
      end
    endcase
    if (f_v < sat_lo) begin
      sat_v = sat_lo;
    end else if (f_v > sat_hi) begin
      sat_v = sat_hi;
    end else begin
      sat_v = f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_prod    <= running_value * cfg.scale;
      d_diff    <= {running_value[31], running_value} - {cfg.zero_lvl[31], cfg.zero_lvl};
      e_q       <= {d_prod[63], d_prod} + {{16{cfg.bias[48]}}, cfg.bias};
      e_diff    <= d_diff;
      f_v       <= cfg.scale_on ? quo : {{16{e_diff[32]}}, e_diff};
      out_pixel <= f_ctl.summary ? 32'd0 : sat_v[31:0];
    end
  end

endmodule
`default_nettype wire
